[hdl/mother_vertex_finder_macros.svh]
// assertion helpers used by the datapath
`ifndef MOTHER_VERTEX_FINDER_MACROS_SVH
`define MOTHER_VERTEX_FINDER_MACROS_SVH

// clocked property, disabled while reset is held
`define MVF_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication, disabled while reset is held
`define MVF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/mvf_pkg.sv]
`timescale 1ns / 1ps
package mvf_pkg;

  // graph size and derived widths
  localparam int MAX_VERTICES = 16;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int CW           = $clog2(MAX_VERTICES + 1);

  // field widths
  localparam int ROW_W       = 4;
  localparam int EDGE_W      = 16;
  localparam int CFG_W       = 5;
  localparam int VERT_W      = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int EXT_W       = (EDGE_W > MAX_VERTICES) ? EDGE_W : MAX_VERTICES;
  localparam int IDX_W       = (VERT_W > VW) ? VERT_W : VW;

  localparam logic [CFG_W-1:0] VCOUNT_RST = CFG_W'(16);

  typedef logic [MAX_VERTICES-1:0] vset_t;
  typedef logic [VW-1:0]           vidx_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROOT,
    S_POP,
    S_EXPAND,
    S_P2,
    S_DONE
  } state_e;

  // datapath operations
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_ROOT_INC,
    CMD_ROOT_TAKE,
    CMD_POP,
    CMD_EXPAND,
    CMD_P2_INIT,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic load_row;
  } cmd_t;

  typedef struct packed {
    logic root_end;
    logic root_seen;
    logic stack_empty;
    logic todo_empty;
    logic out_free;
  } status_t;

endpackage

[hdl/mvf_ctrl.sv]
`timescale 1ns / 1ps
module mvf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  mvf_pkg::status_t status_i,
  output mvf_pkg::cmd_t    cmd_o
);
  import mvf_pkg::*;

  state_e state_q, state_d;
  logic   pass2_q, pass2_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_last_i) state_d = S_INIT;
      end
      S_INIT: state_d = S_ROOT;
      S_ROOT: begin
        if (status_i.root_end) state_d = S_P2;
        else if (!status_i.root_seen) state_d = S_POP;
      end
      S_POP: begin
        if (!status_i.stack_empty) state_d = S_EXPAND;
        else if (pass2_q) state_d = S_DONE;
        else state_d = S_ROOT;
      end
      S_EXPAND: begin
        if (status_i.todo_empty) state_d = S_POP;
      end
      S_P2: state_d = S_POP;
      S_DONE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
    endcase
  end

  // second pass flag
  always_comb begin
    pass2_d = pass2_q;
    if (state_q == S_INIT) pass2_d = 1'b0;
    else if (state_q == S_P2) pass2_d = 1'b1;
  end

  // commands to the datapath
  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    cmd_o.load_row = accept;
    cmd_o.op       = CMD_NONE;
    unique case (state_q)
      S_IDLE: cmd_o.op = CMD_NONE;
      S_INIT: cmd_o.op = CMD_INIT;
      S_ROOT: begin
        if (status_i.root_end) cmd_o.op = CMD_NONE;
        else if (status_i.root_seen) cmd_o.op = CMD_ROOT_INC;
        else cmd_o.op = CMD_ROOT_TAKE;
      end
      S_POP: begin
        if (!status_i.stack_empty) cmd_o.op = CMD_POP;
        else if (pass2_q) cmd_o.op = CMD_NONE;
        else cmd_o.op = CMD_ROOT_INC;
      end
      S_EXPAND: begin
        if (!status_i.todo_empty) cmd_o.op = CMD_EXPAND;
      end
      S_P2: cmd_o.op = CMD_P2_INIT;
      S_DONE: begin
        if (status_i.out_free) cmd_o.op = CMD_FINISH;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
    end
  end

endmodule

[hdl/mvf_datapath.sv]
`timescale 1ns / 1ps
`include "mother_vertex_finder_macros.svh"
module mvf_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mvf_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [mvf_pkg::ROW_W-1:0]   row_index_i,
  input  logic [mvf_pkg::EDGE_W-1:0]  row_edges_i,
  input  mvf_pkg::cmd_t               cmd_i,
  output mvf_pkg::status_t            status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        source_exists_o,
  output logic [mvf_pkg::VERT_W-1:0]  source_vertex_o
);
  import mvf_pkg::*;

  // configuration and adjacency rows
  logic [CFG_W-1:0] vcount_q;
  vset_t            adj_q [MAX_VERTICES];
  vset_t            row_vld_q, row_vld_d;

  // search state
  vset_t            visit_q, visit_d;
  vset_t            todo_q, todo_d;
  vidx_t            stk_q [MAX_VERTICES];
  logic [CW-1:0]    depth_q, depth_d;
  logic [CW-1:0]    root_q, root_d;
  vidx_t            cand_q, cand_d;

  // result register
  logic              out_vld_q, out_vld_d;
  logic              out_exists_q, out_exists_d;
  logic [VERT_W-1:0] out_vert_q, out_vert_d;

  logic [CW-1:0]    n_used;
  vset_t            cols;
  logic [CW-1:0]    depth_m1;
  vidx_t            top_idx, vtop, root_idx, todo_j;
  vset_t            adj_rd, todo_pop, todo_oh, root_oh, cand_oh, row_fit;
  logic [EXT_W-1:0] edges_ext;
  logic [IDX_W-1:0] ridx_ext, cand_ext;
  vidx_t            ridx;
  logic             row_ok, push_ok, push_en;
  vidx_t            push_val;

  // vertices in use, clamped to one..max
  always_comb begin
    int vc;
    vc = int'(vcount_q);
    if (vc < 1) n_used = CW'(1);
    else if (vc > MAX_VERTICES) n_used = CW'(MAX_VERTICES);
    else n_used = CW'(vc);
  end

  // column mask of the vertices in use
  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      cols[k] = (k < int'(n_used));
    end
  end

  // incoming row fitted to the matrix width
  assign edges_ext = EXT_W'(row_edges_i);
  assign row_fit   = edges_ext[MAX_VERTICES-1:0];
  assign ridx_ext  = IDX_W'(row_index_i);
  assign ridx      = ridx_ext[VW-1:0];
  assign row_ok    = (int'(row_index_i) < MAX_VERTICES);

  // top of stack and its unvisited neighbors
  assign depth_m1 = depth_q - 1'b1;
  assign top_idx  = depth_m1[VW-1:0];
  assign vtop     = stk_q[top_idx];
  assign adj_rd   = row_vld_q[vtop] ? adj_q[vtop] : '0;
  assign todo_pop = adj_rd & cols & ~visit_q;

  // lowest pending neighbor
  assign todo_oh = todo_q & (~todo_q + vset_t'(1));
  always_comb begin
    todo_j = '0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (todo_oh[k]) todo_j = todo_j | VW'(k);
    end
  end

  assign root_idx = root_q[VW-1:0];
  assign root_oh  = vset_t'(1) << root_idx;
  assign cand_oh  = vset_t'(1) << cand_q;
  assign push_ok  = (depth_q < CW'(MAX_VERTICES));
  assign cand_ext = IDX_W'(cand_q);

  // next values per command
  always_comb begin
    visit_d      = visit_q;
    todo_d       = todo_q;
    depth_d      = depth_q;
    root_d       = root_q;
    cand_d       = cand_q;
    row_vld_d    = row_vld_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_exists_d = out_exists_q;
    out_vert_d   = out_vert_q;
    push_en      = 1'b0;
    push_val     = root_idx;
    unique case (cmd_i.op)
      CMD_NONE: begin
      end
      CMD_INIT: begin
        visit_d = '0;
        root_d  = '0;
        depth_d = '0;
      end
      CMD_ROOT_INC: root_d = root_q + 1'b1;
      CMD_ROOT_TAKE: begin
        cand_d   = root_idx;
        visit_d  = visit_q | root_oh;
        push_en  = 1'b1;
        push_val = root_idx;
        depth_d  = depth_q + 1'b1;
      end
      CMD_POP: begin
        depth_d = depth_m1;
        todo_d  = todo_pop;
      end
      CMD_EXPAND: begin
        visit_d = visit_q | todo_oh;
        todo_d  = todo_q & ~todo_oh;
        if (push_ok) begin
          push_en  = 1'b1;
          push_val = todo_j;
          depth_d  = depth_q + 1'b1;
        end
      end
      CMD_P2_INIT: begin
        visit_d  = cand_oh;
        push_en  = 1'b1;
        push_val = cand_q;
        depth_d  = depth_q + 1'b1;
      end
      CMD_FINISH: begin
        out_vld_d    = 1'b1;
        out_exists_d = &(visit_q | ~cols);
        out_vert_d   = cand_ext[VERT_W-1:0];
        row_vld_d    = '0;
      end
    endcase
    if (cmd_i.load_row && row_ok) row_vld_d[ridx] = 1'b1;
  end

  // control and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= VCOUNT_RST;
      row_vld_q <= '0;
      visit_q   <= '0;
      todo_q    <= '0;
      depth_q   <= '0;
      root_q    <= '0;
      cand_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      row_vld_q <= row_vld_d;
      visit_q   <= visit_d;
      todo_q    <= todo_d;
      depth_q   <= depth_d;
      root_q    <= root_d;
      cand_q    <= cand_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && row_ok) adj_q[ridx] <= row_fit;
    if (push_en) stk_q[depth_q[VW-1:0]] <= push_val;
    out_exists_q <= out_exists_d;
    out_vert_q   <= out_vert_d;
  end

  // status to the controller
  assign status_o.root_end    = (root_q >= n_used);
  assign status_o.root_seen   = visit_q[root_idx];
  assign status_o.stack_empty = (depth_q == '0);
  assign status_o.todo_empty  = (todo_q == '0);
  assign status_o.out_free    = !out_vld_q || out_ready_i;

  assign out_valid_o     = out_vld_q;
  assign source_exists_o = out_exists_q;
  assign source_vertex_o = out_vert_q;

  // checks
  `MVF_ASSERT_CLK(a_depth_bound, depth_q <= CW'(MAX_VERTICES), "stack depth over capacity")
  `MVF_ASSERT_IMPL(a_expand_work, cmd_i.op == CMD_EXPAND, todo_q != '0, "expand with no work")
  `MVF_ASSERT_CLK(a_finish_clear, (cmd_i.op == CMD_FINISH) |=> (row_vld_q == '0), "rows kept")
  `MVF_ASSERT_IMPL(a_finish_free, cmd_i.op == CMD_FINISH, !out_vld_q || out_ready_i,
                   "result overwritten")

endmodule

[hdl/mother_vertex_finder.sv]
`timescale 1ns / 1ps
// row beats are taken one per cycle while the block is idle
// the last row starts a depth-first search from each unvisited root index in turn,
// then a second search from the last root taken checks that it reaches every vertex in use
// the result register loads in the done state, once no earlier result is pending or it is being taken
// rows of the next frame are taken from the cycle after the result loads
// reset clears the row valid bits, the search state and sets vertex_count to 16
module mother_vertex_finder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mvf_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [3:0] row_index, [19:4] row_edges, [23:20] zero
  input  logic [mvf_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] source_exists, [4:1] source_vertex, [7:5] zero
  output logic [mvf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import mvf_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic              src_exists;
  logic [VERT_W-1:0] src_vertex;

  // sequencer
  mvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // matrix, stack and result
  mvf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .row_index_i     (s_axis_tdata_i[ROW_W-1:0]),
    .row_edges_i     (s_axis_tdata_i[ROW_W+EDGE_W-1:ROW_W]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .source_exists_o (src_exists),
    .source_vertex_o (src_vertex)
  );

  // output beat packing
  assign m_axis_tdata_o = {3'b000, src_vertex, src_exists};

endmodule

[tb/mother_vertex_finder_test.sv]
`timescale 1ns / 1ps
module mother_vertex_finder_test;
  import mvf_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 200;
  localparam int ROW_TARGET = 1150;

  typedef struct packed {
    logic       exists;
    logic [3:0] vertex;
  } answer_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // [3:0] row_index, [19:4] row_edges, [23:20] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // [0] source_exists, [4:1] source_vertex, [7:5] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // predictor state: stored matrix rows and the vertex count register
  logic [EDGE_W-1:0] graph_rows [MAX_VERTICES];
  logic [CFG_W-1:0]  vertex_count_q;
  answer_t           answer_q [$];
  int                mismatches = 0;
  int                rows_sent;
  int                quiet_cycles;
  bit                no_gaps;

  mother_vertex_finder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // vertex count in use after clamping
  function automatic int active_vertices();
    int n;
    n = int'(vertex_count_q);
    if (n < 1) n = 1;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    return n;
  endfunction

  function automatic logic [EDGE_W-1:0] column_mask(int n);
    return (n >= EDGE_W) ? '1 : EDGE_W'((32'd1 << n) - 1);
  endfunction

  // closure of vertices reachable from root over the stored rows
  function automatic logic [EDGE_W-1:0] reach_set(int root, int n, logic [EDGE_W-1:0] cols);
    logic [EDGE_W-1:0] seen;
    seen = EDGE_W'(1) << root;
    repeat (n) begin
      for (int v = 0; v < n; v++) begin
        if (seen[v]) seen |= graph_rows[v] & cols;
      end
    end
    return seen;
  endfunction

  // candidate is the last root taken in ascending order, then a check from it
  function automatic answer_t mother_vertex_answer();
    answer_t           ans;
    int                n;
    int                cand;
    logic [EDGE_W-1:0] cols;
    logic [EDGE_W-1:0] seen;
    n = active_vertices();
    cols = column_mask(n);
    seen = '0;
    cand = 0;
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        cand = i;
        seen |= reach_set(i, n, cols);
      end
    end
    seen = reach_set(cand, n, cols);
    ans.exists = ((seen & cols) == cols);
    ans.vertex = 4'(cand);
    return ans;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // result sink with random stalls
  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (no_gaps || $urandom_range(0, 99) < 60) begin
        m_axis_tready_i <= 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        m_axis_tready_i <= 1'b0;
        hold = pick_gap() - 1;
      end
    end
  end

  // compare each result beat with the oldest expected answer
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.exists = m_axis_tdata_o[0];
      got.vertex = m_axis_tdata_o[4:1];
      if (answer_q.size() == 0) begin
        $error("result beat with no answer pending: exists %0d vertex %0d",
               got.exists, got.vertex);
        mismatches++;
      end else begin
        want = answer_q.pop_front();
        if (got.exists !== want.exists) begin
          $error("source_exists: expected %0d, got %0d", want.exists, got.exists);
          mismatches++;
        end
        if (got.vertex !== want.vertex) begin
          $error("source_vertex: expected %0d, got %0d", want.vertex, got.vertex);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("mother_vertex_finder_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drop valid; called at a falling edge before any wait
  task automatic hold_sender();
    s_axis_tvalid_i <= 1'b0;
  endtask

  // send one row beat; starts and ends at a falling edge, valid left high
  task automatic send_row(logic [ROW_W-1:0] row, logic [EDGE_W-1:0] edges, bit last);
    int gap;
    gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, edges, row};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rows_sent++;
    graph_rows[row] = edges;
    if (last) begin
      answer_q.push_back(mother_vertex_answer());
      foreach (graph_rows[k]) graph_rows[k] = '0;
    end
    @(negedge clk_i);
  endtask

  // wait for every answer, let the block settle, then write the register
  task automatic set_vertex_count(logic [CFG_W-1:0] value);
    hold_sender();
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vertex_count_q = value;
  endtask

  // single-row graphs at the reset count of 16
  task automatic test_single_row_graphs();
    send_row(4'd15, 16'hFFFF, 1'b1);
    send_row(4'd0, 16'h0000, 1'b1);
  endtask

  // repeated rows, rows and columns beyond the count
  task automatic test_row_rules();
    set_vertex_count(5'd4);
    send_row(4'd3, 16'h0004, 1'b0);
    send_row(4'd2, 16'h0001, 1'b0);
    send_row(4'd2, 16'h0002, 1'b0);
    send_row(4'd9, 16'hFFFF, 1'b0);
    send_row(4'd1, 16'hFFF1, 1'b0);
    send_row(4'd0, 16'hFFF0, 1'b1);
    set_vertex_count(5'd2);
    send_row(4'd1, 16'h0001, 1'b1);
  endtask

  // zero count, one vertex, counts above the maximum
  task automatic test_count_limits();
    set_vertex_count(5'd0);
    send_row(4'd0, 16'hFFFF, 1'b1);
    set_vertex_count(5'd1);
    send_row(4'd7, 16'h0080, 1'b0);
    send_row(4'd0, 16'h0000, 1'b1);
    set_vertex_count(5'd31);
    send_row(4'd0, 16'hFFFE, 1'b1);
    set_vertex_count(5'd17);
    send_row(4'd7, 16'h8000, 1'b0);
    send_row(4'd15, 16'h0001, 1'b1);
    set_vertex_count(5'd16);
    send_row(4'd10, 16'h5555, 1'b0);
    send_row(4'd5, 16'hAAAA, 1'b1);
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CFG_W'($urandom_range(1, 4));
    if (r < 70) return CFG_W'($urandom_range(1, 16));
    if (r < 85) return CFG_W'(16);
    if (r < 92) return '0;
    return CFG_W'($urandom_range(17, 31));
  endfunction

  // one graph frame: a rooted tree plus extra edges, or random rows
  task automatic send_graph_frame(bit rooted);
    logic [EDGE_W-1:0] rows_v [MAX_VERTICES];
    int                tree_order [MAX_VERTICES];
    int                send_order [MAX_VERTICES];
    logic [EDGE_W-1:0] cols;
    int                n;
    int                j;
    int                t;
    int                dens;
    n = active_vertices();
    cols = column_mask(n);
    dens = $urandom_range(0, 2);
    for (int k = 0; k < MAX_VERTICES; k++) begin
      tree_order[k] = k;
      send_order[k] = k;
      case (dens)
        0: rows_v[k] = 16'($urandom & $urandom & $urandom);
        1: rows_v[k] = 16'($urandom & $urandom);
        default: rows_v[k] = 16'($urandom);
      endcase
      if (rooted) rows_v[k] &= 16'($urandom & $urandom & $urandom & $urandom);
    end
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = tree_order[k]; tree_order[k] = tree_order[j]; tree_order[j] = t;
      j = $urandom_range(0, k);
      t = send_order[k]; send_order[k] = send_order[j]; send_order[j] = t;
    end
    // spanning tree from a random root
    if (rooted) begin
      for (int k = 1; k < n; k++) begin
        rows_v[tree_order[$urandom_range(0, k - 1)]][tree_order[k]] = 1'b1;
      end
      // occasionally break the tree
      if ($urandom_range(0, 99) < 15) rows_v[$urandom_range(0, n - 1)] = '0;
    end
    // keep high columns clean most of the time
    if ($urandom_range(0, 99) < 60) begin
      for (int k = 0; k < MAX_VERTICES; k++) rows_v[k] &= cols;
    end
    // a stray row beyond the count
    if (n < MAX_VERTICES && $urandom_range(0, 99) < 25) begin
      send_row(4'($urandom_range(n, MAX_VERTICES - 1)), 16'($urandom), 1'b0);
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) begin
        send_row(4'(send_order[k]), rows_v[send_order[k]], 1'b1);
      end else if (rows_v[send_order[k]] != '0 || $urandom_range(0, 1)) begin
        send_row(4'(send_order[k]), rows_v[send_order[k]], 1'b0);
        // a decoy row for the next index, replaced only if the real row is sent later
        if ($urandom_range(0, 99) < 5) begin
          send_row(4'(send_order[k + 1]), 16'($urandom), 1'b0);
        end
      end
    end
  endtask

  // random rows at random indices
  task automatic send_noise_frame();
    int count;
    count = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      send_row(4'($urandom), 16'($urandom), k == count - 1);
    end
  endtask

  task automatic test_random_frames();
    int frames;
    int r;
    frames = 0;
    while (rows_sent < ROW_TARGET) begin
      if (frames % 4 == 0) set_vertex_count(pick_count());
      no_gaps = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) send_graph_frame(1'b1);
      else if (r < 80) send_graph_frame(1'b0);
      else send_noise_frame();
      frames++;
    end
    no_gaps = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    no_gaps         = 1'b0;
    rows_sent       = 0;
    vertex_count_q  = VCOUNT_RST;
    foreach (graph_rows[k]) graph_rows[k] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_row_graphs();
    test_row_rules();
    test_count_limits();
    test_random_frames();

    // drain and let the block go quiet
    hold_sender();
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("mother_vertex_finder_test OK");
    end else begin
      $display("mother_vertex_finder_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/mvf_pkg.sv
hdl/mvf_ctrl.sv
hdl/mvf_datapath.sv
hdl/mother_vertex_finder.sv
tb/mother_vertex_finder_test.sv
